// ----- rtl/dlp_pkg.sv -----
`default_nettype none

package dlp_pkg;

  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_RET  = 2'd2;

  localparam logic [2:0] KIND_ECHO     = 3'd0;
  localparam logic [2:0] KIND_LINE_END = 3'd1;
  localparam logic [2:0] KIND_DATE_OK  = 3'd2;
  localparam logic [2:0] KIND_FMT_ERR  = 3'd3;
  localparam logic [2:0] KIND_FEB_FLAG = 3'd4;

  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int          RUN_W        = 14;
  localparam logic [13:0] RUN_CAP      = 14'd9999;
  localparam logic [2:0]  FLD_DAY      = 3'd0;
  localparam logic [2:0]  FLD_MONTH    = 3'd1;
  localparam logic [2:0]  FLD_YEAR     = 3'd2;
  localparam logic [2:0]  FLD_HOUR     = 3'd3;
  localparam logic [2:0]  FLD_MINUTE   = 3'd4;
  localparam logic [2:0]  FLD_SECOND   = 3'd5;
  localparam logic [3:0]  FEB_MONTH    = 4'd2;
  localparam logic [4:0]  FEB_LAST_DAY = 5'd28;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        last;
  } result_t;

  function automatic logic [13:0] field_lo(input logic [2:0] f);
    logic [13:0] v;
    unique case (f)
      FLD_DAY:    v = 14'd1;
      FLD_MONTH:  v = 14'd1;
      FLD_YEAR:   v = 14'd1970;
      default:    v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic logic [13:0] field_hi(input logic [2:0] f);
    logic [13:0] v;
    unique case (f)
      FLD_DAY:    v = 14'd31;
      FLD_MONTH:  v = 14'd12;
      FLD_YEAR:   v = 14'd2099;
      FLD_HOUR:   v = 14'd23;
      default:    v = 14'd59;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] sep_char(input logic [2:0] f);
    logic [7:0] v;
    unique case (f)
      FLD_DAY:    v = CH_SLASH;
      FLD_MONTH:  v = CH_SLASH;
      FLD_YEAR:   v = CH_SPACE;
      default:    v = CH_COLON;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dlp_front.sv -----
`default_nettype none

module dlp_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output dlp_pkg::cmd_t    cmd
);

  logic          valid;
  dlp_pkg::cmd_t cmd_reg;
  logic [1:0]    op_class;

  assign in_ready  = !valid || cmd_ready;
  assign cmd_valid = valid;
  assign cmd       = cmd_reg;

  always_comb begin
    priority if (in_byte == dlp_pkg::CH_DEL) begin
      op_class = dlp_pkg::OP_DEL;
    end else if (in_byte == dlp_pkg::CH_CR) begin
      op_class = dlp_pkg::OP_RET;
    end else begin
      op_class = dlp_pkg::OP_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_reg.op   <= op_class;
      cmd_reg.data <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dlp_queue.sv -----
`default_nettype none

module dlp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire dlp_pkg::cmd_t  push_cmd,
  output logic                pop_valid,
  input  wire logic           pop,
  output dlp_pkg::cmd_t       pop_cmd
);

  dlp_pkg::cmd_t                entries [dlp_pkg::Q_DEPTH];
  logic [dlp_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [dlp_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [dlp_pkg::Q_CNT_W-1:0]  count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = count != dlp_pkg::Q_CNT_W'(dlp_pkg::Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dlp_back.sv -----
`default_nettype none

module dlp_back #(
  parameter int LINE_DEPTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire dlp_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  output logic                res_valid,
  input  wire logic           res_ready,
  output dlp_pkg::result_t    res
);

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam logic [IDX_W-1:0] FULL_FILL = IDX_W'(LINE_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEL1  = 3'd1;
  localparam logic [2:0] S_DEL2  = 3'd2;
  localparam logic [2:0] S_PARSE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [7:0]       line_mem [LINE_DEPTH];
  logic [7:0]       rd_data;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] fill, fill_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [2:0]       fld, fld_next;
  logic [13:0]      acc, acc_next;
  logic [2:0]       res_kind, res_kind_next;
  logic [4:0]       day;
  logic [3:0]       month;
  logic [11:0]      year;
  logic [4:0]       hour;
  logic [5:0]       minute;
  logic [5:0]       second;

  logic             slot_ok;
  logic             emit;
  dlp_pkg::result_t emit_res;
  logic             wr_en;
  logic             store_en;
  logic             at_end;
  logic             is_digit;
  logic             sep_ok;
  logic             range_ok;
  logic [16:0]      acc_sum;
  logic [13:0]      acc_sat;
  logic             feb_flag;

  assign slot_ok  = !res_valid || res_ready;
  assign at_end   = pos >= fill;
  assign is_digit = !at_end && rd_data >= dlp_pkg::CH_ZERO && rd_data <= dlp_pkg::CH_NINE;
  assign sep_ok   = !at_end && rd_data == dlp_pkg::sep_char(fld);
  assign range_ok = acc >= dlp_pkg::field_lo(fld) && acc <= dlp_pkg::field_hi(fld);
  assign acc_sum  = (17'(acc) << 3) + (17'(acc) << 1) + 17'(rd_data[3:0]);
  assign acc_sat  = (acc_sum > 17'(dlp_pkg::RUN_CAP)) ? dlp_pkg::RUN_CAP : acc_sum[13:0];
  assign feb_flag = month == dlp_pkg::FEB_MONTH && day > dlp_pkg::FEB_LAST_DAY;

  always_comb begin
    q_pop         = 1'b0;
    emit          = 1'b0;
    emit_res      = '0;
    wr_en         = 1'b0;
    store_en      = 1'b0;
    state_next    = state;
    fill_next     = fill;
    pos_next      = pos;
    fld_next      = fld;
    acc_next      = acc;
    res_kind_next = res_kind;
    unique case (state)
      S_IDLE: begin
        if (q_valid && slot_ok) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            dlp_pkg::OP_CHAR: begin
              if (fill < FULL_FILL) begin
                wr_en            = 1'b1;
                fill_next        = fill + 1'b1;
                emit             = 1'b1;
                emit_res.kind    = dlp_pkg::KIND_ECHO;
                emit_res.tx_byte = q_cmd.data;
                emit_res.last    = 1'b1;
              end
            end
            dlp_pkg::OP_DEL: begin
              if (fill != '0) begin
                emit             = 1'b1;
                emit_res.kind    = dlp_pkg::KIND_ECHO;
                emit_res.tx_byte = dlp_pkg::CH_BS;
                fill_next        = fill - 1'b1;
                state_next       = S_DEL1;
              end
            end
            dlp_pkg::OP_RET: begin
              if (fill != '0) begin
                emit          = 1'b1;
                emit_res.kind = dlp_pkg::KIND_LINE_END;
                pos_next      = '0;
                fld_next      = dlp_pkg::FLD_DAY;
                acc_next      = '0;
                state_next    = S_PARSE;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEL1: begin
        if (slot_ok) begin
          emit             = 1'b1;
          emit_res.kind    = dlp_pkg::KIND_ECHO;
          emit_res.tx_byte = dlp_pkg::CH_SPACE;
          state_next       = S_DEL2;
        end
      end
      S_DEL2: begin
        if (slot_ok) begin
          emit             = 1'b1;
          emit_res.kind    = dlp_pkg::KIND_ECHO;
          emit_res.tx_byte = dlp_pkg::CH_BS;
          emit_res.last    = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_PARSE: begin
        priority if (is_digit) begin
          acc_next = acc_sat;
          pos_next = pos + 1'b1;
        end else if (!range_ok) begin
          res_kind_next = dlp_pkg::KIND_FMT_ERR;
          state_next    = S_DONE;
        end else begin
          store_en = 1'b1;
          priority if (fld == dlp_pkg::FLD_SECOND) begin
            res_kind_next = feb_flag ? dlp_pkg::KIND_FEB_FLAG : dlp_pkg::KIND_DATE_OK;
            state_next    = S_DONE;
          end else if (sep_ok) begin
            pos_next = pos + 1'b1;
            fld_next = fld + 1'b1;
            acc_next = '0;
          end else begin
            res_kind_next = dlp_pkg::KIND_FMT_ERR;
            state_next    = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (slot_ok) begin
          emit          = 1'b1;
          emit_res.kind = res_kind;
          emit_res.last = 1'b1;
          if (res_kind != dlp_pkg::KIND_FMT_ERR) begin
            emit_res.day    = day;
            emit_res.month  = month;
            emit_res.year   = year;
            emit_res.hour   = hour;
            emit_res.minute = minute;
            emit_res.second = second;
          end
          fill_next  = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    fld      <= fld_next;
    acc      <= acc_next;
    res_kind <= res_kind_next;
    if (emit) begin
      res <= emit_res;
    end
    if (store_en) begin
      unique case (fld)
        dlp_pkg::FLD_DAY:    day    <= acc[4:0];
        dlp_pkg::FLD_MONTH:  month  <= acc[3:0];
        dlp_pkg::FLD_YEAR:   year   <= acc[11:0];
        dlp_pkg::FLD_HOUR:   hour   <= acc[4:0];
        dlp_pkg::FLD_MINUTE: minute <= acc[5:0];
        default:             second <= acc[5:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[fill] <= q_cmd.data;
    end
    rd_data <= line_mem[pos_next];
  end

endmodule

`default_nettype wire

// ----- rtl/date_line_parser.sv -----
// serial console line editor with date and time parser
// s_axis carries received bytes, one byte per word; m_axis carries results,
// and one input byte gives zero to three result words, the final one with
// tlast set
// an ordinary byte is echoed (tuser 0) and stored while the line holds fewer
// than LINE_DEPTH-1 bytes; delete echoes backspace, space, backspace
// return on a non-empty line gives a line end word (tuser 1), then the parse
// outcome: 2 date accepted, 3 format error, 4 accepted but february day flagged
// input passes the front register, a queue entry, then the result register
// echo and delete words stream at one per cycle while tready is high; a return
// scans the stored line one character per cycle from the line memory, and its
// last word follows the end of that scan
// a four-entry command queue lets input keep flowing while results stall
// when the receiver holds tready low the result register keeps its word and
// the line engine waits before its next word; input stalls only once the queue is full
// synchronous reset empties the line, the queue and the result register
`default_nettype none

module date_line_parser #(
  parameter int LINE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // tx_byte, day, month, year, hour, minute, second
  output logic [2:0]       m_axis_tuser,   // kind
  output logic             m_axis_tlast
);

  logic             f_valid;
  logic             f_ready;
  dlp_pkg::cmd_t    f_cmd;
  logic             q_valid;
  logic             q_pop;
  dlp_pkg::cmd_t    q_cmd;
  dlp_pkg::result_t res;

  dlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  dlp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  dlp_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {2'b00, res.second, res.minute, res.hour, res.year,
                         res.month, res.day, res.tx_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ----- rtl/dlp_checker.sv -----
`default_nettype none

module dlp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != dlp_pkg::KIND_ECHO |-> m_axis_tdata[7:0] == 8'd0)
    else $error("echo byte set on a non-echo word");

  a_no_date: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == dlp_pkg::KIND_LINE_END ||
                      m_axis_tuser == dlp_pkg::KIND_FMT_ERR) |-> m_axis_tdata[47:8] == 40'd0)
    else $error("date fields set on a word without a date");

  a_line_end_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == dlp_pkg::KIND_LINE_END |-> !m_axis_tlast)
    else $error("line end word marked last");

  a_outcome_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == dlp_pkg::KIND_DATE_OK ||
                      m_axis_tuser == dlp_pkg::KIND_FMT_ERR ||
                      m_axis_tuser == dlp_pkg::KIND_FEB_FLAG) |-> m_axis_tlast)
    else $error("parse outcome word not marked last");

endmodule

bind date_line_parser dlp_checker u_checker (.*);

`default_nettype wire

// ----- tb/date_line_checker.sv -----
module date_line_checker
  import dlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [47:0] out_data,   // tx_byte, day, month, year, hour, minute, second
  input  wire logic [2:0]  out_kind,
  input  wire logic        out_last,
  output int               fail_count,
  output int               pending
);

  localparam int unsigned LINE_MAX = 31;
  localparam int unsigned DIGIT_SAT = 9999;
  localparam int unsigned LO_LIM [6] = '{1, 1, 1970, 0, 0, 0};
  localparam int unsigned HI_LIM [6] = '{31, 12, 2099, 23, 59, 59};
  localparam logic [7:0] SEP_SEQ [5] = '{CH_SLASH, CH_SLASH, CH_SPACE, CH_COLON, CH_COLON};

  logic [7:0]  line_buf [0:31];
  int unsigned line_len;
  int unsigned date_val [6];
  result_t     word_q [$];
  result_t     got_word;
  result_t     want_word;
  int          mismatches;

  function automatic string fmt_word(input result_t w);
    return $sformatf("kind %0d tx %h date %0d/%0d/%0d %0d:%0d:%0d last %0b",
                     w.kind, w.tx_byte, w.day, w.month, w.year, w.hour, w.minute,
                     w.second, w.last);
  endfunction

  // digit runs with separators, range checks, february flag
  function automatic logic [2:0] parse_date();
    int unsigned pos;
    int unsigned v;
    pos = 0;
    for (int k = 0; k < 6; k++) date_val[k] = 0;
    for (int k = 0; k < 6; k++) begin
      v = 0;
      while (pos < line_len && line_buf[pos] >= CH_ZERO && line_buf[pos] <= CH_NINE) begin
        v = v * 10 + (line_buf[pos] - CH_ZERO);
        if (v > DIGIT_SAT) v = DIGIT_SAT;
        pos++;
      end
      if (v < LO_LIM[k] || v > HI_LIM[k]) return KIND_FMT_ERR;
      date_val[k] = v;
      if (k < 5) begin
        if (pos >= line_len || line_buf[pos] != SEP_SEQ[k]) return KIND_FMT_ERR;
        pos++;
      end
    end
    if (date_val[1] == 2 && date_val[0] > 28) return KIND_FEB_FLAG;
    return KIND_DATE_OK;
  endfunction

  task automatic push_word(input logic [2:0] kind, input logic [7:0] tx,
                           input logic with_date, input logic last);
    result_t w;
    w = '0;
    w.kind = kind;
    w.tx_byte = tx;
    if (with_date) begin
      w.day = 5'(date_val[0]);
      w.month = 4'(date_val[1]);
      w.year = 12'(date_val[2]);
      w.hour = 5'(date_val[3]);
      w.minute = 6'(date_val[4]);
      w.second = 6'(date_val[5]);
    end
    w.last = last;
    word_q.push_back(w);
  endtask

  task automatic take_byte(input logic [7:0] c);
    logic [2:0] k;
    if (c == CH_DEL) begin
      if (line_len != 0) begin
        push_word(KIND_ECHO, CH_BS, 1'b0, 1'b0);
        push_word(KIND_ECHO, CH_SPACE, 1'b0, 1'b0);
        push_word(KIND_ECHO, CH_BS, 1'b0, 1'b1);
        line_len--;
      end
    end else if (c == CH_CR) begin
      if (line_len != 0) begin
        push_word(KIND_LINE_END, 8'h00, 1'b0, 1'b0);
        k = parse_date();
        push_word(k, 8'h00, k != KIND_FMT_ERR, 1'b1);
        line_len = 0;
      end
    end else if (line_len < LINE_MAX) begin
      line_buf[line_len] = c;
      line_len++;
      push_word(KIND_ECHO, c, 1'b0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      word_q.delete();
      line_len = 0;
      mismatches = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got_word = '0;
        got_word.kind = out_kind;
        got_word.tx_byte = out_data[7:0];
        got_word.day = out_data[12:8];
        got_word.month = out_data[16:13];
        got_word.year = out_data[28:17];
        got_word.hour = out_data[33:29];
        got_word.minute = out_data[39:34];
        got_word.second = out_data[45:40];
        got_word.last = out_last;
        if (word_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %s", fmt_word(got_word));
        end else begin
          want_word = word_q.pop_front();
          if (got_word !== want_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch expected: %s", fmt_word(want_word));
              $display("         actual:   %s", fmt_word(got_word));
            end
          end
        end
      end
      if (in_valid && in_ready) take_byte(in_byte);
      fail_count <= mismatches;
      pending <= word_q.size();
    end
  end

endmodule

// ----- tb/tb_date_line_parser.sv -----
module tb_date_line_parser;
  import dlp_pkg::*;

  localparam int ITEM_TARGET = 410;
  localparam int IDLE_LIMIT = 20000;
  localparam int unsigned LO_LIM [6] = '{1, 1, 1970, 0, 0, 0};
  localparam int unsigned HI_LIM [6] = '{31, 12, 2099, 23, 59, 59};
  localparam logic [7:0] SEP_SEQ [5] = '{CH_SLASH, CH_SLASH, CH_SPACE, CH_COLON, CH_COLON};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int         fail_count;
  int         pending;
  int         sent = 0;
  int         rx_hold = 0;
  bit         rx_steady = 1'b0;
  bit         tx_steady = 1'b0;
  int         idle_cycles = 0;
  logic [7:0] line_q [$];

  always #4 clk = ~clk;

  date_line_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  date_line_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_kind   (m_axis_tuser),
    .out_last   (m_axis_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_hold <= 0;
      rx_steady <= 1'b0;
    end else begin
      if ($urandom_range(0, 399) == 0) rx_steady <= ~rx_steady;
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        rx_hold <= gap_len();
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // hold the sender until every predicted word has come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic append_str(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic append_num(input int unsigned v, input int pad);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < pad) s = {"0", s};
    append_str(s);
  endtask

  function automatic int unsigned pick_field(input int k);
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return (LO_LIM[k] == 0) ? 0 : LO_LIM[k] - 1;
      1: return LO_LIM[k];
      2: return HI_LIM[k];
      3: return HI_LIM[k] + 1;
      4: return $urandom_range(10000, 99999);
      default: return $urandom_range(LO_LIM[k], HI_LIM[k]);
    endcase
  endfunction

  task automatic date_line();
    int unsigned vals [6];
    int pad;
    int pos;
    for (int k = 0; k < 6; k++) vals[k] = pick_field(k);
    if ($urandom_range(0, 3) == 0) begin
      vals[1] = 2;
      vals[0] = $urandom_range(27, 31);
    end
    for (int k = 0; k < 6; k++) begin
      pad = (k == 2) ? 4 : 2;
      case ($urandom_range(0, 9))
        0: pad = pad + $urandom_range(1, 3);
        1: pad = 1;
        default: ;
      endcase
      append_num(vals[k], pad);
      if (k < 5) line_q.push_back(SEP_SEQ[k]);
    end
    pos = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 11))
      0: line_q[pos] = 8'($urandom_range(0, 255));
      1: line_q.delete(pos);
      2: append_str(" ok");
      3: begin
        line_q.insert(pos, CH_DEL);
        line_q.insert(pos, 8'($urandom_range(32, 126)));
      end
      4: begin
        line_q.push_front(CH_DEL);
        line_q.push_front(CH_DEL);
        line_q.push_front(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    line_q.push_back(CH_CR);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // delete and return on an empty line, byte extremes, delete, bad line, february 29 line
    send_byte(CH_DEL);
    send_byte(CH_CR);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CH_DEL);
    send_byte(8'h00);
    send_byte(CH_CR);
    append_str("29/02/2024 00:00:00");
    line_q.push_back(CH_CR);
    send_line();
    wait_idle();

    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 6) == 0) tx_steady = ~tx_steady;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: date_line();
        13, 14, 15: begin
          repeat ($urandom_range(1, 40)) line_q.push_back(8'($urandom_range(0, 255)));
          line_q.push_back(CH_CR);
        end
        16, 17: begin
          // overfill, then edit from a full line
          repeat ($urandom_range(31, 36)) line_q.push_back(8'($urandom_range(32, 126)));
          repeat ($urandom_range(0, 3)) line_q.push_back(CH_DEL);
          repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(48, 57)));
          line_q.push_back(CH_CR);
        end
        default: begin
          case ($urandom_range(0, 2))
            0: line_q.push_back(CH_DEL);
            1: line_q.push_back(CH_CR);
            default: line_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      endcase
      send_line();
      if ($urandom_range(0, 19) == 0) wait_idle();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dlp_pkg.sv
rtl/dlp_front.sv
rtl/dlp_queue.sv
rtl/dlp_back.sv
rtl/date_line_parser.sv
rtl/dlp_checker.sv
tb/date_line_checker.sv
tb/tb_date_line_parser.sv
